// File: rtl/core/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg: shared definitions for the cubic solarisation tone map
// Widths of the fixed-point datapath, register indexes and reset values,
// and the sideband record that travels with each word down the pipeline.
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int G_W       = 8;   // subpixel width
  localparam int COORD_W   = 9;   // curve space coordinate width
  localparam int FRAC_W    = 16;  // fractional bits of the Q16 values
  localparam int P_W       = COORD_W + 3;           // signed 4g - x1 - x2
  localparam int PMAG_W    = COORD_W + 1;           // magnitude of p
  localparam int N_W       = PMAG_W + FRAC_W;       // dividend and quotient
  localparam int DIV_BITS  = 2;                     // quotient bits per stage
  localparam int DIV_STAGES = N_W / DIV_BITS;
  localparam int T2_W      = 2 * N_W - FRAC_W;      // t squared, Q16
  localparam int SPLIT_W   = T2_W / 2;              // low half of t squared
  localparam int PP_W      = (T2_W - SPLIT_W) + N_W; // partial product width
  localparam int T3_W      = T2_W + N_W - FRAC_W;   // t cubed, Q16
  localparam int Q3_W      = N_W + 2;               // 3t
  localparam int M_W       = T3_W + 1;              // signed 3t - t cubed
  localparam int DY_W      = COORD_W + 1;           // signed y1 - y2
  localparam int PR_W      = DY_W + M_W;            // dy * s
  localparam int BASE_W    = COORD_W + 1 + FRAC_W - 1; // (y1+y2) * 2^15
  localparam int Y_W       = PR_W;                  // curve height, Q16
  localparam int OUT_SHIFT = FRAC_W + 1;            // y / 2^17
  localparam int POLY_STAGES = 7;

  localparam logic [COORD_W-1:0] X1_RESET = COORD_W'(128);
  localparam logic [COORD_W-1:0] Y1_RESET = COORD_W'(384);
  localparam logic [COORD_W-1:0] X2_RESET = COORD_W'(384);
  localparam logic [COORD_W-1:0] Y2_RESET = COORD_W'(128);
  localparam logic [G_W-1:0]     G_MAX    = '1;

  typedef enum logic [1:0] {
    CFG_FIRST_X  = 2'd0,
    CFG_FIRST_Y  = 2'd1,
    CFG_SECOND_X = 2'd2,
    CFG_SECOND_Y = 2'd3
  } cfg_reg_t;

  // Carried alongside the arithmetic so the last stage can pick the result.
  typedef struct packed {
    logic [G_W-1:0] g;    // original subpixel
    logic           deg;  // both extrema share x
    logic           neg;  // sign of t
  } csm_side_t;

endpackage

// File: rtl/core/csm_div.sv
// ----------------------------------------------------------------------------
// csm_div: pipelined unsigned restoring divider
// DIV_BITS quotient bits per stage and a new dividend each cycle adv is high.
// The user, not the divider, keeps the divisor steady while words are in flight.
// ----------------------------------------------------------------------------
module csm_div
  import csm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [N_W-1:0]       in_num,
  input  csm_side_t            in_side,
  input  logic [COORD_W-1:0]   den,
  output logic                 out_valid,
  output logic [N_W-1:0]       out_quot,
  output csm_side_t            out_side
);

  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [N_W-1:0]     work;  // dividend bits shift out the top, quotient in
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [COORD_W-1:0] d);
    logic [COORD_W:0] trial;
    div_state_t       r;
    trial  = {s.rem, s.work[N_W-1]};
    r.work = {s.work[N_W-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      trial     = trial - {1'b0, d};
      r.work[0] = 1'b1;
    end
    r.rem = trial[COORD_W-1:0];
    return r;
  endfunction

  logic [DIV_STAGES-1:0] valid;
  div_state_t            st      [DIV_STAGES];
  div_state_t            st_next [DIV_STAGES];
  csm_side_t             side    [DIV_STAGES];

  always_comb begin
    div_state_t src;
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        src.rem  = '0;
        src.work = in_num;
      end else begin
        src = st[i-1];
      end
      for (int j = 0; j < DIV_BITS; j++) begin
        src = div_step(src, den);
      end
      st_next[i] = src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= in_side;
      for (int i = 0; i < DIV_STAGES; i++) begin
        st[i] <= st_next[i];
      end
      for (int i = 1; i < DIV_STAGES; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = valid[DIV_STAGES-1];
  assign out_quot  = st[DIV_STAGES-1].work;
  assign out_side  = side[DIV_STAGES-1];

endmodule

// File: rtl/core/csm_poly.sv
// ----------------------------------------------------------------------------
// csm_poly: cubic evaluation pipeline
// From |t| in Q16 forms t^2, t^3, s = 3t - t^3 and the curve height
// y = (y1+y2)*2^15 + trunc(dy*s/4), with a multiply or a wide add in each stage.
// ----------------------------------------------------------------------------
module csm_poly
  import csm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [N_W-1:0]           in_quot,
  input  csm_side_t                in_side,
  input  logic signed [DY_W-1:0]   dy,
  input  logic [BASE_W-1:0]        base,
  output logic                     out_valid,
  output logic signed [Y_W-1:0]    out_y,
  output csm_side_t                out_side
);

  logic [POLY_STAGES-1:0] valid;
  csm_side_t              side [POLY_STAGES];

  // Stage 1: square.
  logic [2*N_W-1:0]       sq_c;
  logic [N_W-1:0]         q1;
  logic [T2_W-1:0]        t2;
  // Stage 2: t^2 * t split in two halves.
  logic [PP_W-1:0]        ph, pl;
  logic [Q3_W-1:0]        q3;
  // Stage 3: recombine and drop the fraction.
  logic [PP_W+SPLIT_W-1:0] pp_sum_c;
  logic [T3_W-1:0]        t3;
  logic [Q3_W-1:0]        q3b;
  // Stage 4: s for |t| and signed slope.
  logic signed [M_W-1:0]  m;
  logic signed [DY_W-1:0] dys;
  // Stage 5 to 7.
  logic signed [PR_W-1:0] prod_c, prod;
  logic signed [PR_W-1:0] biased_c;
  logic signed [PR_W-3:0] qd;
  logic signed [Y_W-1:0]  y;

  assign sq_c     = in_quot * in_quot;
  assign pp_sum_c = {ph, {SPLIT_W{1'b0}}} + {{SPLIT_W{1'b0}}, pl};
  assign prod_c   = dys * m;
  // Truncation toward zero of a quarter: bias negative values before the shift.
  assign biased_c = prod + (prod[PR_W-1] ? PR_W'(signed'(3)) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[POLY_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= in_side;
      for (int i = 1; i < POLY_STAGES; i++) begin
        side[i] <= side[i-1];
      end
      q1  <= in_quot;
      t2  <= sq_c[2*N_W-1:FRAC_W];
      ph  <= t2[T2_W-1:SPLIT_W] * q1;
      pl  <= t2[SPLIT_W-1:0] * q1;
      q3  <= ({2'b00, q1} << 1) + {2'b00, q1};
      t3  <= pp_sum_c[PP_W+SPLIT_W-1:FRAC_W];
      q3b <= q3;
      m   <= signed'({{(M_W-Q3_W){1'b0}}, q3b}) - signed'({1'b0, t3});
      dys <= side[2].neg ? -dy : dy;
      prod <= prod_c;
      qd  <= biased_c[PR_W-1:2];
      y   <= signed'({{(Y_W-BASE_W){1'b0}}, base}) + {{2{qd[PR_W-3]}}, qd};
    end
  end

  assign out_valid = valid[POLY_STAGES-1];
  assign out_y     = y;
  assign out_side  = side[POLY_STAGES-1];

endmodule

// File: rtl/core/cubic_solarisation_tone_map_top.sv
// ----------------------------------------------------------------------------
// cubic_solarisation_tone_map_top: per-subpixel cubic tone curve
// Usage: words enter on the s_ channel (8-bit subpixel in s_tdata[7:0]) and
// leave on the m_ channel, mapped value in m_tdata[7:0] and the degenerate
// curve flag in m_tuser. The two curve extrema are set through cfg_we,
// cfg_index and cfg_data; the user must set them only while no word is in
// flight, as the block itself does not enforce it. Throughput: one word per
// clock while the output is not stalled. A word passes through 22 register
// stages: one input stage (loaded at the accepting edge), a 13-stage divider
// producing two quotient bits per stage, a 7-stage polynomial pipeline and
// the output register. All stages move together; when the receiver holds
// m_tready low with a word waiting, the whole pipeline holds and s_tready
// drops, so nothing is lost or repeated. A bubble at the output lets the
// pipeline advance. Reset (rst, synchronous) empties the pipeline and loads
// the extrema (128, 384) and (384, 128).
// When both extrema share x, the subpixel passes through and m_tuser is 1.
// ----------------------------------------------------------------------------
module cubic_solarisation_tone_map_top
  import csm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] subpixel_in
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [7:0] subpixel_out
  output logic               m_tuser,   // [0] degenerate_curve
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);

  logic [COORD_W-1:0] x1, y1, x2, y2;
  logic               adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= X1_RESET;
      y1 <= Y1_RESET;
      x2 <= X2_RESET;
      y2 <= Y2_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FIRST_X:  x1 <= cfg_data;
        CFG_FIRST_Y:  y1 <= cfg_data;
        CFG_SECOND_X: x2 <= cfg_data;
        CFG_SECOND_Y: y2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derived from the extrema; held stable in flight by the user, not the block.
  logic [COORD_W-1:0]     dmag;
  logic signed [DY_W-1:0] dy;
  logic [BASE_W-1:0]      base;
  logic [COORD_W:0]       ysum;

  assign dmag = (x1 >= x2) ? (x1 - x2) : (x2 - x1);
  assign dy   = signed'({1'b0, y1}) - signed'({1'b0, y2});
  assign ysum = {1'b0, y1} + {1'b0, y2};
  assign base = {ysum, {(FRAC_W-1){1'b0}}};

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Input stage: p = 4g - x1 - x2 as sign and magnitude.
  logic signed [P_W-1:0] p_c;
  logic [PMAG_W-1:0]     pmag_c;
  logic                  f_valid;
  logic [N_W-1:0]        f_num;
  csm_side_t             f_side;

  assign p_c    = signed'({2'b00, s_tdata, 2'b00}) - signed'({3'b000, x1})
                  - signed'({3'b000, x2});
  assign pmag_c = p_c[P_W-1] ? PMAG_W'(-p_c) : PMAG_W'(p_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_num      <= {pmag_c, {FRAC_W{1'b0}}};
      f_side.g   <= s_tdata;
      f_side.deg <= (x1 == x2);
      f_side.neg <= p_c[P_W-1] ^ (x1 < x2);
    end
  end

  logic           d_valid;
  logic [N_W-1:0] d_quot;
  csm_side_t      d_side;

  csm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_side   (f_side),
    .den       (dmag),
    .out_valid (d_valid),
    .out_quot  (d_quot),
    .out_side  (d_side)
  );

  logic                  p_valid;
  logic signed [Y_W-1:0] p_y;
  csm_side_t             p_side;

  csm_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .in_quot   (d_quot),
    .in_side   (d_side),
    .dy        (dy),
    .base      (base),
    .out_valid (p_valid),
    .out_y     (p_y),
    .out_side  (p_side)
  );

  // Output register: scale by 2^-17 and saturate to the subpixel range.
  logic [G_W-1:0] sat_c;

  always_comb begin
    if (p_y[Y_W-1]) begin
      sat_c = '0;
    end else if (|p_y[Y_W-2:OUT_SHIFT+G_W]) begin
      sat_c = G_MAX;
    end else begin
      sat_c = p_y[OUT_SHIFT+G_W-1:OUT_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= p_side.deg ? p_side.g : sat_c;
      m_tuser <= p_side.deg;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_loads_front: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> f_valid)
    else $error("accepted word did not reach the input stage");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(f_valid) && $stable(d_valid)
      && $stable(p_valid))
    else $error("pipeline moved while the output was stalled");

  a_output_from_poly: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(p_valid))
    else $error("output word appeared without a finished pipeline word");
`endif

endmodule
